// File: src/ctpt_pkg.sv
// Package for the pairwise duel tally: sizes, field widths, command codes,
// shared types and the rank compare function.
// No dependencies; every other file of the block imports it.
package ctpt_pkg;

  localparam int CANDIDATES = 8;
  localparam longint unsigned MAX_BALLOTS = 64'd65535;

  localparam int IDX_W    = (CANDIDATES > 1) ? $clog2(CANDIDATES) : 1;
  localparam int POS_W    = $clog2(CANDIDATES + 1);
  localparam int CNT_W    = 16;
  localparam int CMD_W    = 2;
  localparam int RANK_W   = 5;
  localparam int SEL_W    = 4;
  localparam int MARGIN_W = 16;

  // Counters stop at the smaller of the ballot limit and the counter range.
  localparam logic [CNT_W-1:0] WIN_CAP =
    (MAX_BALLOTS < 64'd65535) ? CNT_W'(MAX_BALLOTS) : {CNT_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_RANK   = 2'd1,
    CMD_PAIR   = 2'd2,
    CMD_WINNER = 2'd3
  } cmd_e;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic                  unranked;
    logic [RANK_W-2:0]     value;
  } rank_t;

  typedef struct packed {
    rank_t             rank;
    logic [IDX_W-1:0]  id;
  } token_t;

  typedef struct packed {
    logic              clear;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_sel;
    rank_t             wr_rank;
    logic              load;
    logic [POS_W-1:0]  pos;
    logic              step;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
  } cell_ctl_t;

  // Any negative rank means unranked.
  function automatic rank_t decode_rank(logic [RANK_W-1:0] raw);
    rank_t r;
    r.unranked = raw[RANK_W-1];
    r.value    = raw[RANK_W-2:0];
    return r;
  endfunction

  // Equal ranks beat nobody; a ranked candidate beats an unranked one.
  function automatic logic beats(rank_t a, rank_t b);
    return !a.unranked && (b.unranked || (a.value < b.value));
  endfunction

endpackage

// File: src/ctpt_if.sv
// Valid/ready channel interfaces for requests and results of the duel tally.
// Depends on ctpt_pkg for the field widths.
interface ctpt_req_if import ctpt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [RANK_W-1:0] rank;
  logic                     last;
  logic [SEL_W-1:0]         row;
  logic [SEL_W-1:0]         col;

  modport source (output valid, cmd, rank, last, row, col, input ready);
  modport sink   (input valid, cmd, rank, last, row, col, output ready);
endinterface

interface ctpt_rsp_if import ctpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MARGIN_W-1:0] margin;
  logic                winner_found;
  logic [SEL_W-1:0]    winner_index;

  modport source (output valid, margin, winner_found, winner_index, input ready);
  modport sink   (input valid, margin, winner_found, winner_index, output ready);
endinterface

// File: src/ctpt_cell.sv
// One candidate cell: its ballot rank slot, its row of win counters and one
// stage of the token ring used while a ballot is tallied. Uses ctpt_pkg.
module ctpt_cell import ctpt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] id,
  input  cell_ctl_t        ctl,
  input  token_t           tok_in,
  output token_t           tok_out,
  output cnt_t             rd_data
);

  rank_t            slot;
  rank_t            mine;
  token_t           tok;
  cnt_t             cnt [CANDIDATES];
  rank_t            eff;
  logic             hit;
  logic [IDX_W-1:0] rd_addr;

  // Slots past the received elements of the ballot count as unranked.
  always_comb begin
    if (POS_W'(id) < ctl.pos) begin
      eff = slot;
    end else begin
      eff = '{unranked: 1'b1, value: '0};
    end
    hit     = ctl.step && beats(mine, tok.rank) && (cnt[tok.id] < WIN_CAP);
    rd_addr = (id == ctl.row) ? ctl.col : ctl.row;
  end

  assign tok_out = tok;

  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_sel == id)) begin
      slot <= ctl.wr_rank;
    end
    if (ctl.load) begin
      mine <= eff;
      tok  <= '{rank: eff, id: id};
    end else if (ctl.step) begin
      tok <= tok_in;
    end
    rd_data <= cnt[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int k = 0; k < CANDIDATES; k++) begin
        cnt[k] <= '0;
      end
    end else if (hit) begin
      cnt[tok.id] <= cnt[tok.id] + 1'b1;
    end
  end

endmodule

// File: src/ctpt_chain.sv
// Row of candidate cells closed into a ring: each cell hands its rank token
// to the next cell every tally cycle. Uses ctpt_pkg and ctpt_cell.
module ctpt_chain import ctpt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  output cnt_t      rd_data [CANDIDATES]
);

  token_t ring [CANDIDATES];

  for (genvar g = 0; g < CANDIDATES; g++) begin : g_cell
    ctpt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .id      (IDX_W'(g)),
      .ctl     (ctl),
      .tok_in  (ring[(g + CANDIDATES - 1) % CANDIDATES]),
      .tok_out (ring[g]),
      .rd_data (rd_data[g])
    );
  end

endmodule

// File: src/condorcet_pairwise_tally.sv
// Pairwise duel tally: top level with the control sequencer and result register.
// Clear and rank requests are taken in idle; a closing rank passes through a load
// state and a tally state while the rank tokens circle the cell ring. A pair query
// passes through a read state and an emit state; a winner query scans the matrix
// one entry a cycle. Synchronous reset zeroes all counters and the ballot position.
// Uses ctpt_pkg, ctpt_if and ctpt_chain.
module condorcet_pairwise_tally import ctpt_pkg::*; (
  input logic        clk,
  input logic        rst,
  ctpt_req_if.sink   req,
  ctpt_rsp_if.source rsp
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_TALLY = 6'b000100,
    ST_READ  = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CANDIDATES - 1);

  state_t            state;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [IDX_W-1:0]  tcnt;
  logic [IDX_W-1:0]  qrow;
  logic [IDX_W-1:0]  qcol;
  logic              qok;
  logic              is_pair;
  logic [IDX_W-1:0]  si;
  logic [IDX_W-1:0]  sj;
  logic [IDX_W-1:0]  si_d;
  logic [IDX_W-1:0]  sj_d;
  logic              issuing;
  logic              pend;
  logic              row_ok;
  logic              row_ok_next;
  logic              found;
  logic [IDX_W-1:0]  widx;
  logic              out_valid;
  cnt_t              out_margin;
  logic              out_found;
  logic [SEL_W-1:0]  out_index;
  cnt_t              pair_margin;
  logic              accept;
  logic              emit;
  cmd_e              cmd;
  cell_ctl_t         ctl;
  cnt_t              rd_data [CANDIDATES];

  ctpt_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_data (rd_data)
  );

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.margin       = out_margin;
  assign rsp.winner_found = out_found;
  assign rsp.winner_index = out_index;

  always_comb begin
    accept   = req.valid && req.ready;
    emit     = (state == ST_EMIT) && (!out_valid || rsp.ready);
    cmd      = cmd_e'(req.cmd);
    pos_next = (pos < POS_W'(CANDIDATES)) ? POS_W'(pos + 1'b1) : pos;

    ctl         = '0;
    ctl.clear   = accept && (cmd == CMD_CLEAR);
    ctl.wr_en   = accept && (cmd == CMD_RANK) && (pos < POS_W'(CANDIDATES));
    ctl.wr_sel  = pos[IDX_W-1:0];
    ctl.wr_rank = decode_rank(req.rank);
    ctl.load    = (state == ST_LOAD);
    ctl.pos     = pos;
    ctl.step    = (state == ST_TALLY);
    ctl.row     = (state == ST_SCAN) ? si : qrow;
    ctl.col     = (state == ST_SCAN) ? sj : qcol;

    if (qok && (rd_data[qrow] > rd_data[qcol])) begin
      pair_margin = rd_data[qrow] - rd_data[qcol];
    end else begin
      pair_margin = '0;
    end

    // Cell si_d read wins of si_d over sj_d, cell sj_d the reverse.
    row_ok_next = row_ok &&
                  ((si_d == sj_d) || (rd_data[si_d] > rd_data[sj_d]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      issuing   <= 1'b0;
      pend      <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_CLEAR: begin
                pos <= '0;
              end
              CMD_RANK: begin
                pos <= pos_next;
                if (req.last) begin
                  state <= ST_LOAD;
                end
              end
              CMD_PAIR: begin
                qrow    <= req.row[IDX_W-1:0];
                qcol    <= req.col[IDX_W-1:0];
                qok     <= (int'(req.row) < CANDIDATES) &&
                           (int'(req.col) < CANDIDATES) && (req.row != req.col);
                is_pair <= 1'b1;
                state   <= ST_READ;
              end
              default: begin
                si      <= '0;
                sj      <= '0;
                issuing <= 1'b1;
                pend    <= 1'b0;
                row_ok  <= 1'b1;
                found   <= 1'b0;
                widx    <= '0;
                is_pair <= 1'b0;
                state   <= ST_SCAN;
              end
            endcase
          end
        end
        ST_LOAD: begin
          tcnt  <= '0;
          state <= ST_TALLY;
        end
        ST_TALLY: begin
          if (tcnt == LAST_IDX) begin
            pos   <= '0;
            state <= ST_IDLE;
          end else begin
            tcnt <= tcnt + 1'b1;
          end
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_SCAN: begin
          pend <= issuing;
          if (issuing) begin
            si_d <= si;
            sj_d <= sj;
            if (sj == LAST_IDX) begin
              sj <= '0;
              if (si == LAST_IDX) begin
                issuing <= 1'b0;
              end else begin
                si <= si + 1'b1;
              end
            end else begin
              sj <= sj + 1'b1;
            end
          end
          if (pend) begin
            if (sj_d == LAST_IDX) begin
              row_ok <= 1'b1;
              // The first row that wins every duel is kept.
              if (row_ok_next && !found) begin
                found <= 1'b1;
                widx  <= si_d;
              end
              if (si_d == LAST_IDX) begin
                state <= ST_EMIT;
              end
            end else begin
              row_ok <= row_ok_next;
            end
          end
        end
        ST_EMIT: begin
          if (emit) begin
            out_margin <= is_pair ? pair_margin : '0;
            out_found  <= is_pair ? 1'b0 : found;
            out_index  <= is_pair ? '0 : SEL_W'(widx);
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A tally always has at least one received element or a full ballot.
  a_tally_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TALLY) |-> (pos != '0))
    else $error("tally running with empty ballot position");

  a_pair_read: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.cmd == CMD_PAIR)) |=> (state == ST_READ))
    else $error("pair query did not start a counter read");

  a_no_winner_idx: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.winner_found) |-> (rsp.winner_index == '0))
    else $error("winner index set without a winner");

  a_winner_kept: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && $past(state == ST_SCAN) && $past(found)) |-> $stable(widx))
    else $error("winner index changed after a winner was found");

endmodule
